/* src/sbcs_pkg.sv */
package sbcs_pkg;

  localparam int ENTRIES   = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int SLOT_W    = 6;
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int TIME_W    = 31;

  // Doubled-coordinate differences fit in 35 bits; shifted numerator in 35+FRAC_BITS.
  localparam int DIFF_W    = 36;
  localparam int NUM_W     = DIFF_W + FRAC_BITS;
  localparam int DEN_W     = 34;
  localparam int QUO_W     = NUM_W;
  localparam int DIST_W    = 65;

  localparam logic signed [QUO_W-1:0] TMAX = QUO_W'(64'sd2147483647);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] NRM_NEG_X = 2'd0;
  localparam logic [1:0] NRM_POS_X = 2'd1;
  localparam logic [1:0] NRM_NEG_Y = 2'd2;
  localparam logic [1:0] NRM_POS_Y = 2'd3;

  typedef struct packed {
    logic                 action;
    logic [SLOT_W-1:0]    slot;
    logic                 entry_valid;
    logic                 exclude_self;
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic [SIZE_W-1:0]    size_x;
    logic [SIZE_W-1:0]    size_y;
    logic signed [31:0]   vel_x;
    logic signed [31:0]   vel_y;
  } in_beat_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    hit_slot;
    logic [TIME_W-1:0]    hit_time;
    logic [1:0]           normal;
  } out_beat_t;

endpackage

/* src/sbcs_if.sv */
interface sbcs_in_if;
  logic               valid;
  logic               ready;
  sbcs_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbcs_out_if;
  logic                valid;
  logic                ready;
  sbcs_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/sbcs_div.sv */
module sbcs_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [sbcs_pkg::NUM_W-1:0]   num,
  input  logic signed [sbcs_pkg::DEN_W-1:0]   den,
  output logic                                done,
  output logic signed [sbcs_pkg::QUO_W-1:0]   quo
);

  localparam int N = sbcs_pkg::NUM_W;
  localparam int D = sbcs_pkg::DEN_W;
  localparam int C_W = $clog2(N + 1);

  logic [N-1:0]   q_r, q_nxt;
  logic [D:0]     rem_r, rem_nxt;
  logic [D-1:0]   dmag_r, dmag_nxt;
  logic           neg_r, neg_nxt;
  logic [C_W-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [D:0]     trial;
  logic [D:0]     shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[D-1:0], q_r[N-1]};
    trial    = shifted - {1'b0, dmag_r};
    if (start) begin
      q_nxt    = num[N-1] ? N'(-num) : N'(num);
      dmag_nxt = den[D-1] ? D'(-den) : D'(den);
      neg_nxt  = num[N-1] ^ den[D-1];
      rem_nxt  = '0;
      cnt_nxt  = C_W'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[D]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - C_W'(1);
      if (cnt_r == C_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

/* src/swept_box_collision_search.sv */
// Load beat: table write takes effect at once.
// Query beat: each slot is read in turn, then the scan finishes; a slot in use (and not
// excluded as self) is checked and, if it survives, goes through four divisions on the
// shared restoring divider (none for a zero-velocity axis), then is ranked. A query with
// zero velocity on both axes goes straight to a miss result.
// Throughput: one beat at a time; in_ready is low while a query runs or a result waits.
// Reset (rst_n low, synchronous) clears all slots to unused and idles.
module swept_box_collision_search (
  input  logic       clk,
  input  logic       rst_n,
  sbcs_in_if.sink    in_ch,
  sbcs_out_if.source out_ch
);

  localparam int IW = sbcs_pkg::IDX_W;
  localparam int CW = sbcs_pkg::CNT_W;
  localparam int NW = sbcs_pkg::NUM_W;
  localparam int DW = sbcs_pkg::DEN_W;
  localparam int QW = sbcs_pkg::QUO_W;
  localparam int FW = sbcs_pkg::DIFF_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_WAIT  = 8'b0001_0000,
    ST_EVAL  = 8'b0010_0000,
    ST_DIST  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0]             mem_cx [sbcs_pkg::ENTRIES];
  logic signed [31:0]             mem_cy [sbcs_pkg::ENTRIES];
  logic [sbcs_pkg::SIZE_W-1:0]    mem_w  [sbcs_pkg::ENTRIES];
  logic [sbcs_pkg::SIZE_W-1:0]    mem_h  [sbcs_pkg::ENTRIES];
  logic [sbcs_pkg::ENTRIES-1:0]   used_r;

  sbcs_pkg::in_beat_t q_r;
  logic [CW-1:0]      idx_r;
  logic [IW-1:0]      cur_r;
  logic signed [31:0] cx_r, cy_r;
  logic [sbcs_pkg::SIZE_W-1:0] w_r, h_r;

  logic signed [FW-1:0] lox_r, hix_r, loy_r, hiy_r;
  logic signed [FW-1:0] p2x, p2y;
  logic [1:0]           dcnt_r;
  logic signed [QW-1:0] t_r [4];

  logic                 found_r;
  logic signed [QW-1:0] bt_r;
  logic [IW-1:0]        bslot_r;
  logic [1:0]           bnorm_r;
  logic [sbcs_pkg::DIST_W-1:0] bd_r;
  logic signed [QW-1:0] ct_r;
  logic [1:0]           cnorm_r;
  logic [sbcs_pkg::DIST_W-1:0] cd_r;
  logic [1:0]           sq_ph_r;
  logic [63:0]          sqa_r;

  logic                 out_valid_r;
  sbcs_pkg::out_beat_t  out_r;

  logic                 div_start;
  logic signed [NW-1:0] div_num;
  logic signed [DW-1:0] div_den;
  logic                 div_done;
  logic signed [QW-1:0] div_quo;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;

  // table write
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.data.action == sbcs_pkg::ACT_LOAD && in_ch.data.entry_valid
        && 32'(in_ch.data.slot) < 32'(sbcs_pkg::ENTRIES)) begin
      mem_cx[IW'(in_ch.data.slot)] <= in_ch.data.pos_x;
      mem_cy[IW'(in_ch.data.slot)] <= in_ch.data.pos_y;
      mem_w[IW'(in_ch.data.slot)]  <= in_ch.data.size_x;
      mem_h[IW'(in_ch.data.slot)]  <= in_ch.data.size_y;
    end
    if (state_r == ST_READ) begin
      cx_r  <= mem_cx[idx_r[IW-1:0]];
      cy_r  <= mem_cy[idx_r[IW-1:0]];
      w_r   <= mem_w[idx_r[IW-1:0]];
      h_r   <= mem_h[idx_r[IW-1:0]];
      cur_r <= idx_r[IW-1:0];
    end
  end

  assign p2x = FW'(q_r.pos_x) <<< 1;
  assign p2y = FW'(q_r.pos_y) <<< 1;

  // slab bounds of the current entry
  logic signed [FW-1:0] lox, hix, loy, hiy;
  always_comb begin
    lox = (FW'(cx_r) <<< 1) - FW'({1'b0, w_r}) - FW'({1'b0, q_r.size_x});
    hix = (FW'(cx_r) <<< 1) + FW'({1'b0, w_r}) + FW'({1'b0, q_r.size_x});
    loy = (FW'(cy_r) <<< 1) - FW'({1'b0, h_r}) - FW'({1'b0, q_r.size_y});
    hiy = (FW'(cy_r) <<< 1) + FW'({1'b0, h_r}) + FW'({1'b0, q_r.size_y});
  end

  logic vx0, vy0, vxp, vyp;
  assign vx0 = (q_r.vel_x == 32'sd0);
  assign vy0 = (q_r.vel_y == 32'sd0);
  assign vxp = !q_r.vel_x[31] && !vx0;
  assign vyp = !q_r.vel_y[31] && !vy0;

  logic xrej, yrej;
  always_comb begin
    if (vx0)       xrej = (p2x <= lox) || (p2x >= hix);
    else if (vxp)  xrej = (p2x >= hix);
    else           xrej = (p2x <= lox);
    if (vy0)       yrej = (p2y <= loy) || (p2y >= hiy);
    else if (vyp)  yrej = (p2y >= hiy);
    else           yrej = (p2y <= loy);
  end

  // division k: 0 x entry, 1 x exit, 2 y entry, 3 y exit
  logic signed [FW-1:0] bnd;
  always_comb begin
    case (dcnt_r)
      2'd0:    bnd = vxp ? lox_r : hix_r;
      2'd1:    bnd = vxp ? hix_r : lox_r;
      2'd2:    bnd = vyp ? loy_r : hiy_r;
      default: bnd = vyp ? hiy_r : loy_r;
    endcase
    div_num = NW'(bnd - (dcnt_r[1] ? p2y : p2x)) <<< sbcs_pkg::FRAC_BITS;
    div_den = dcnt_r[1] ? (DW'(q_r.vel_y) <<< 1) : (DW'(q_r.vel_x) <<< 1);
  end

  logic skip_div;
  assign skip_div = dcnt_r[1] ? vy0 : vx0;
  assign div_start = (state_r == ST_DIV) && !skip_div;

  sbcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  function automatic logic signed [QW-1:0] sat(input logic signed [QW-1:0] t);
    if (t > sbcs_pkg::TMAX) return sbcs_pkg::TMAX;
    if (t < -sbcs_pkg::TMAX) return -sbcs_pkg::TMAX;
    return t;
  endfunction

  logic signed [QW-1:0] xe, xx, ye, yx;
  assign xe = t_r[0];
  assign xx = t_r[1];
  assign ye = t_r[2];
  assign yx = t_r[3];

  logic signed [32:0] dd;
  logic [31:0]        dabs;
  logic [63:0]        sq_prod;
  assign dd      = sq_ph_r[0] ? (33'(cy_r) - 33'(q_r.pos_y)) : (33'(cx_r) - 33'(q_r.pos_x));
  assign dabs    = dd[32] ? 32'(-dd) : 32'(dd);
  assign sq_prod = dabs * dabs;

  logic [sbcs_pkg::DIST_W-1:0] cd_sum;
  assign cd_sum = cd_r + sbcs_pkg::DIST_W'(sqa_r);

  logic better;
  assign better = !found_r || ct_r < bt_r || (ct_r == bt_r && cd_sum < bd_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire && in_ch.data.action == sbcs_pkg::ACT_QUERY) begin
                  state_nxt = (in_ch.data.vel_x == 32'sd0 && in_ch.data.vel_y == 32'sd0)
                              ? ST_OUT : ST_READ;
                end
      ST_READ:  begin
        if (idx_r == CW'(sbcs_pkg::ENTRIES)) state_nxt = ST_OUT;
        else if (used_r[idx_r[IW-1:0]] &&
                 !(q_r.exclude_self && 32'(q_r.slot) == 32'(idx_r)))
          state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = (xrej || yrej) ? ST_READ : ST_DIV;
      ST_DIV:   state_nxt = skip_div ? ((dcnt_r == 2'd3) ? ST_EVAL : ST_DIV) : ST_WAIT;
      ST_WAIT:  if (div_done) state_nxt = (dcnt_r == 2'd3) ? ST_EVAL : ST_DIV;
      ST_EVAL:  state_nxt = (xe > yx || ye > xx || (xe < 0 && ye < 0)) ? ST_READ : ST_DIST;
      ST_DIST:  if (sq_ph_r == 2'd2) state_nxt = ST_READ;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      sq_ph_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_fire) begin
          q_r     <= in_ch.data;
          idx_r   <= '0;
          found_r <= 1'b0;
          if (in_ch.data.action == sbcs_pkg::ACT_LOAD &&
              32'(in_ch.data.slot) < 32'(sbcs_pkg::ENTRIES))
            used_r[IW'(in_ch.data.slot)] <= in_ch.data.entry_valid;
        end
        ST_READ: if (idx_r != CW'(sbcs_pkg::ENTRIES)) idx_r <= idx_r + CW'(1);
        ST_CHECK: begin
          lox_r  <= lox;
          hix_r  <= hix;
          loy_r  <= loy;
          hiy_r  <= hiy;
          dcnt_r <= 2'd0;
        end
        ST_DIV: if (skip_div) begin
          t_r[dcnt_r] <= dcnt_r[0] ? sbcs_pkg::TMAX : -sbcs_pkg::TMAX;
          dcnt_r      <= dcnt_r + 2'd1;
        end
        ST_WAIT: if (div_done) begin
          t_r[dcnt_r] <= sat(div_quo);
          dcnt_r      <= dcnt_r + 2'd1;
        end
        ST_EVAL: begin
          sq_ph_r <= 2'd0;
          if (xe > ye) begin
            ct_r    <= xe;
            cnorm_r <= vxp ? sbcs_pkg::NRM_NEG_X : sbcs_pkg::NRM_POS_X;
          end else begin
            ct_r    <= ye;
            cnorm_r <= vyp ? sbcs_pkg::NRM_NEG_Y : sbcs_pkg::NRM_POS_Y;
          end
        end
        // square x, square y while holding x, then rank on the sum
        ST_DIST: begin
          sqa_r   <= sq_prod;
          sq_ph_r <= sq_ph_r + 2'd1;
          if (sq_ph_r == 2'd1) cd_r <= sbcs_pkg::DIST_W'(sqa_r);
          if (sq_ph_r == 2'd2 && better) begin
            found_r <= 1'b1;
            bt_r    <= ct_r;
            bslot_r <= cur_r;
            bnorm_r <= cnorm_r;
            bd_r    <= cd_sum;
          end
        end
        ST_OUT: begin
          out_valid_r    <= 1'b1;
          out_r.hit      <= found_r;
          out_r.hit_slot <= found_r ? sbcs_pkg::SLOT_W'(bslot_r) : '0;
          out_r.hit_time <= found_r ? bt_r[sbcs_pkg::TIME_W-1:0] : '0;
          out_r.normal   <= found_r ? bnorm_r : sbcs_pkg::NRM_NEG_X;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.hit |-> out_ch.data.hit_time == '0)
    else $error("no-hit time nonzero");

endmodule
